// File: hdl/bpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared widths, register indexes and clamping helpers for the rank decoder.
// ----------------------------------------------------------------------------
package bpr_pkg;

	localparam int NUM_DIMS     = 3;
	localparam int DIM_W        = $clog2(NUM_DIMS);
	localparam int EXTENT_W     = 13;
	localparam int PROCS_W      = 11;
	localparam int RANK_W       = 20;
	localparam int COORD_W      = 10;
	localparam int VOLUME_W     = 37;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 13;

	localparam logic [EXTENT_W-1:0] EXTENT_MAX = 13'd4096;
	localparam logic [PROCS_W-1:0]  PROCS_MAX  = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROCS_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd6;

	function automatic logic [EXTENT_W-1:0] eff_extent(input logic [EXTENT_W-1:0] n);
		return (n > EXTENT_MAX) ? EXTENT_MAX : n;
	endfunction

	// A count of zero behaves as a single process.
	function automatic logic [PROCS_W-1:0] eff_procs(input logic [PROCS_W-1:0] p);
		if (p == '0) return PROCS_W'(1);
		return (p > PROCS_MAX) ? PROCS_MAX : p;
	endfunction

endpackage

// File: hdl/bpr_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_div_pipe
// Restoring divider, one quotient bit per register stage, with side data.
// ----------------------------------------------------------------------------
module bpr_div_pipe #(
	parameter int W  = 20,
	parameter int DW = 11,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [W-1:0]  quot,
	output logic [DW-1:0] rem,
	output logic [SW-1:0] side_out
);

	// The accumulator shifts dividend bits out at the top and quotient bits in
	// at the bottom, so after W stages it holds the whole quotient.
	logic [W-1:0]  acc_s  [W+1];
	logic [DW-1:0] rem_s  [W+1];
	logic [DW-1:0] dvs_s  [W+1];
	logic [SW-1:0] side_s [W+1];
	logic [W:0]    vld_s;

	assign acc_s[0]  = dividend;
	assign rem_s[0]  = '0;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < W; g++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_s[g], acc_s[g][W-1]};
			ge    = trial >= {1'b0, dvs_s[g]};
			diff  = trial - {1'b0, dvs_s[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[g+1]  <= {acc_s[g][W-2:0], ge};
				rem_s[g+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				dvs_s[g+1]  <= dvs_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign quot      = acc_s[W];
	assign rem       = rem_s[W];
	assign side_out  = side_s[W];

endmodule

// File: hdl/bpr_part_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_part_calc
// Part length, start index and local volume from decoded coordinates.
// ----------------------------------------------------------------------------
module bpr_part_calc
	import bpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [COORD_W-1:0]  coord [NUM_DIMS],
	input  logic [EXTENT_W-1:0] quot  [NUM_DIMS],
	input  logic [PROCS_W-1:0]  rem   [NUM_DIMS],
	output logic                out_valid,
	output logic [COORD_W-1:0]  coord_o [NUM_DIMS],
	output logic [EXTENT_W-1:0] size_o  [NUM_DIMS],
	output logic [EXTENT_W-1:0] start_o [NUM_DIMS],
	output logic [VOLUME_W-1:0] volume_o
);

	localparam int PROD_W = COORD_W + EXTENT_W;

	logic                v_s1, v_s2, v_s3;
	logic [COORD_W-1:0]  coord_s1 [NUM_DIMS];
	logic [COORD_W-1:0]  coord_s2 [NUM_DIMS];
	logic [COORD_W-1:0]  coord_s3 [NUM_DIMS];
	logic [EXTENT_W-1:0] len_s1   [NUM_DIMS];
	logic [EXTENT_W-1:0] len_s2   [NUM_DIMS];
	logic [EXTENT_W-1:0] len_s3   [NUM_DIMS];
	logic [PROD_W-1:0]   prod_s1  [NUM_DIMS];
	logic [PROCS_W-1:0]  mn_s1    [NUM_DIMS];
	logic [EXTENT_W-1:0] first_s2 [NUM_DIMS];
	logic [EXTENT_W-1:0] first_s3 [NUM_DIMS];
	logic [2*EXTENT_W-1:0] vol_s2;
	logic [VOLUME_W-1:0] vol_s3;
	logic [3*EXTENT_W-1:0] vol_full;
	logic [PROD_W-1:0]   first_sum [NUM_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			first_sum[i] = prod_s1[i] + PROD_W'(mn_s1[i]);
		end
		vol_full = (3*EXTENT_W)'(vol_s2) * (3*EXTENT_W)'(len_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				// Coordinates below the remainder take one extra point.
				len_s1[i]   <= quot[i] + EXTENT_W'({1'b0, coord[i]} < rem[i]);
				prod_s1[i]  <= PROD_W'(coord[i]) * PROD_W'(quot[i]);
				mn_s1[i]    <= ({1'b0, coord[i]} < rem[i]) ? {1'b0, coord[i]} : rem[i];
				coord_s1[i] <= coord[i];
				first_s2[i] <= first_sum[i][EXTENT_W-1:0];
				len_s2[i]   <= len_s1[i];
				coord_s2[i] <= coord_s1[i];
				first_s3[i] <= first_s2[i];
				len_s3[i]   <= len_s2[i];
				coord_s3[i] <= coord_s2[i];
			end
			vol_s2 <= (2*EXTENT_W)'(len_s1[0]) * (2*EXTENT_W)'(len_s1[1]);
			vol_s3 <= vol_full[VOLUME_W-1:0];
		end
	end

	assign out_valid = v_s3;
	assign coord_o   = coord_s3;
	assign size_o    = len_s3;
	assign start_o   = first_s3;
	assign volume_o  = vol_s3;

endmodule

// File: hdl/block_partition_rank_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_partition_rank_decode
// Decodes a process rank into coordinates, part sizes, starts and volume.
// ----------------------------------------------------------------------------
// Three 20-stage bit-per-stage divider chains produce the coordinates,
// followed by three stages of part arithmetic.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits. Extent/count quotients come from free-running 13-stage dividers.
// Reset clears all valid bits and sets every extent and process count register to 1.
module block_partition_rank_decode
	import bpr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,  // rank[19:0], zero fill
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// coord_x, coord_y, coord_z, size_x, size_y, size_z,
	// start_x, start_y, start_z, local_volume, zero fill
	output logic [151:0]          m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [EXTENT_W-1:0] extent_q [NUM_DIMS];
	logic [PROCS_W-1:0]  procs_q  [NUM_DIMS];
	logic [PROCS_W-1:0]  procs_eff [NUM_DIMS];
	logic [EXTENT_W-1:0] cquot [NUM_DIMS];
	logic [PROCS_W-1:0]  crem  [NUM_DIMS];
	logic                en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				extent_q[i] <= EXTENT_W'(1);
				procs_q[i]  <= PROCS_W'(1);
			end
		end else if (cfg_we) begin
			if (cfg_index < CFG_PROCS_X) begin
				extent_q[DIM_W'(cfg_index - CFG_EXTENT_X)] <= cfg_data[EXTENT_W-1:0];
			end else if (cfg_index < CFG_END) begin
				procs_q[DIM_W'(cfg_index - CFG_PROCS_X)] <= cfg_data[PROCS_W-1:0];
			end
		end
	end

	// The user must keep configuration static while words are in flight; the block does not enforce
	// this. These dividers run freely and settle long before any word needs their results.
	for (genvar a = 0; a < NUM_DIMS; a++) begin : g_axis
		assign procs_eff[a] = eff_procs(procs_q[a]);

		bpr_div_pipe #(.W(EXTENT_W), .DW(PROCS_W), .SW(1)) u_cdiv (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (1'b1),
			.in_valid  (1'b1),
			.dividend  (eff_extent(extent_q[a])),
			.divisor   (procs_eff[a]),
			.side_in   (1'b0),
			.out_valid (),
			.quot      (cquot[a]),
			.rem       (crem[a]),
			.side_out  ()
		);
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Mixed-radix decode: x is rank mod px, y is (rank/px) mod py and z is
	// (rank/(px*py)) mod pz, which also wraps ranks beyond the total.
	logic                v1, v2, v3;
	logic [RANK_W-1:0]   q1, q2;
	logic [PROCS_W-1:0]  r1, r2, r3;
	logic [COORD_W-1:0]  cx2;
	logic [2*COORD_W-1:0] cxy3;
	logic [COORD_W-1:0]  coord [NUM_DIMS];

	bpr_div_pipe #(.W(RANK_W), .DW(PROCS_W), .SW(1)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid),
		.dividend(s_tdata[RANK_W-1:0]), .divisor(procs_eff[0]), .side_in(1'b0),
		.out_valid(v1), .quot(q1), .rem(r1), .side_out()
	);

	bpr_div_pipe #(.W(RANK_W), .DW(PROCS_W), .SW(COORD_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v1),
		.dividend(q1), .divisor(procs_eff[1]), .side_in(r1[COORD_W-1:0]),
		.out_valid(v2), .quot(q2), .rem(r2), .side_out(cx2)
	);

	bpr_div_pipe #(.W(RANK_W), .DW(PROCS_W), .SW(2*COORD_W)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v2),
		.dividend(q2), .divisor(procs_eff[2]), .side_in({r2[COORD_W-1:0], cx2}),
		.out_valid(v3), .quot(), .rem(r3), .side_out(cxy3)
	);

	assign coord[0] = cxy3[COORD_W-1:0];
	assign coord[1] = cxy3[2*COORD_W-1:COORD_W];
	assign coord[2] = r3[COORD_W-1:0];

	logic [COORD_W-1:0]  coord_o [NUM_DIMS];
	logic [EXTENT_W-1:0] size_o  [NUM_DIMS];
	logic [EXTENT_W-1:0] start_o [NUM_DIMS];
	logic [VOLUME_W-1:0] volume_o;

	bpr_part_calc u_part (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v3),
		.coord     (coord),
		.quot      (cquot),
		.rem       (crem),
		.out_valid (m_tvalid),
		.coord_o   (coord_o),
		.size_o    (size_o),
		.start_o   (start_o),
		.volume_o  (volume_o)
	);

	assign m_tdata = {7'd0, volume_o,
		start_o[2], start_o[1], start_o[0],
		size_o[2], size_o[1], size_o[0],
		coord_o[2], coord_o[1], coord_o[0]};

endmodule
